// ===== hdl/servo_reference_wave_generator_defines.svh =====
`ifndef SERVO_REFERENCE_WAVE_GENERATOR_DEFINES_SVH
`define SERVO_REFERENCE_WAVE_GENERATOR_DEFINES_SVH

// Check a condition at every edge out of reset.
`define SRWG_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define SRWG_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== hdl/srwg_pkg.sv =====
package srwg_pkg;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_ENABLE  = 2'd1,
		KIND_DISABLE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SHAPE_SINE   = 2'd0,
		SHAPE_SQUARE = 2'd1,
		SHAPE_OTHER  = 2'd2,
		SHAPE_SPARE  = 2'd3
	} shape_t;

	typedef enum logic [1:0] {
		TGT_POSITION = 2'd0,
		TGT_SPEED    = 2'd1,
		TGT_TORQUE   = 2'd2,
		TGT_NONE     = 2'd3
	} target_t;

	typedef enum logic [2:0] {
		REG_WAVE_SHAPE     = 3'd0,
		REG_CONTROL_TARGET = 3'd1,
		REG_FREQ_INCREMENT = 3'd2,
		REG_AMP_TARGET     = 3'd3,
		REG_RAMP_STEP      = 3'd4
	} reg_index_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 31;

	localparam logic [30:0] AMP_TARGET_RESET = 31'd19661;
	localparam logic [30:0] RAMP_STEP_RESET  = 31'd66;

	// Phase fraction travels left aligned at its widest setting.
	localparam int FRAC_MAX = 48;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SERIES_DIV [0:5] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] position_now;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] reference;
		logic [1:0]         destination;
	} out_item_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	// One result job handed from front to back.
	typedef struct packed {
		logic                square;
		logic                square_hi;
		logic [FRAC_MAX-1:0] frac;
		logic [30:0]         amp;
		logic signed [31:0]  offset;
		logic                add_offset;
		logic [1:0]          dest;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

// ===== hdl/servo_reference_wave_generator.sv =====
// Servo reference wave generator: a sine or square source for a servo loop.
// Send a tick item once per control period; each tick while running advances
// the phase by freq_increment, ramps the amplitude toward amp_target by at most
// ramp_step, and gives one beat of reference plus destination when the shape is
// sine or square and the target is position, speed or torque. Enable restarts
// the phase and latches position_now as the offset added in position mode;
// disable freezes the generator. The block takes one item per clock while the
// job queue has room: result ticks go through a four-entry job queue into a
// four-stage back end (table index, sine table read, amplitude multiply, offset
// add and saturate). The input stalls only when the job queue is full, which
// happens only while the output beat is held back.
// Configuration writes are taken in any cycle and should be made while idle.
module servo_reference_wave_generator
	import srwg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_FRAC_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic      accept;
	logic      push;
	logic      pop;
	job_t      job;
	job_t      head;
	q_status_t qstat;
	cfg_wr_t   cfg_wr;

	// Take a register write in any cycle.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// Hold the input only while there is no room left for a job.
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Front: update phase, amplitude and mode state, classify the beat.
	srwg_front #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.accept (accept),
		.item   (in_item),
		.push   (push),
		.job    (job)
	);

	// Queue: decouple the front from a stalled output.
	srwg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.status   (qstat)
	);

	// Back: look up the sine, scale, add offset, saturate, drive the beat.
	srwg_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== hdl/srwg_front.sv =====
module srwg_front
	import srwg_pkg::*;
#(
	parameter int PHASE_FRAC_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_wr_t  cfg_wr,
	input  logic     accept,
	input  in_item_t item,
	output logic     push,
	output job_t     job
);

	`include "servo_reference_wave_generator_defines.svh"

	localparam int PW = PHASE_FRAC_BITS + 1;

	logic [1:0]        shape_q;
	logic [1:0]        target_q;
	logic [30:0]       freq_q;
	logic [30:0]       amp_tgt_q;
	logic [30:0]       step_q;
	logic [PW-1:0]     phase_q;
	logic [30:0]       amp_q;
	logic signed [31:0] offset_q;
	logic              running_q;

	logic [PW-1:0] phase_nx;
	logic [30:0]   amp_nx;
	logic [31:0]   amp_sum;
	logic [30:0]   amp_diff;
	logic          tick;
	logic          gives_result;

	always_comb begin
		phase_nx = phase_q + PW'(freq_q);
		amp_sum  = {1'b0, amp_q} + {1'b0, step_q};
		amp_diff = amp_q - amp_tgt_q;
		if (amp_q < amp_tgt_q) begin
			amp_nx = (amp_sum > {1'b0, amp_tgt_q}) ? amp_tgt_q : amp_sum[30:0];
		end else if (amp_q > amp_tgt_q) begin
			amp_nx = (amp_diff > step_q) ? (amp_q - step_q) : amp_tgt_q;
		end else begin
			amp_nx = amp_q;
		end
	end

	assign tick = accept && (item.kind == KIND_TICK) && running_q;
	assign gives_result = (shape_q == SHAPE_SINE || shape_q == SHAPE_SQUARE)
		&& (target_q != TGT_NONE);
	assign push = tick && gives_result;

	always_comb begin
		job.square     = (shape_q == SHAPE_SQUARE);
		job.square_hi  = (target_q == TGT_POSITION) ? phase_nx[PHASE_FRAC_BITS]
			: phase_nx[PHASE_FRAC_BITS-1];
		job.frac       = FRAC_MAX'(phase_nx[PHASE_FRAC_BITS-1:0]) << (FRAC_MAX - PHASE_FRAC_BITS);
		job.amp        = amp_nx;
		job.offset     = offset_q;
		job.add_offset = (target_q == TGT_POSITION);
		job.dest       = target_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q   <= SHAPE_OTHER;
			target_q  <= TGT_POSITION;
			freq_q    <= '0;
			amp_tgt_q <= AMP_TARGET_RESET;
			step_q    <= RAMP_STEP_RESET;
			phase_q   <= '0;
			amp_q     <= AMP_TARGET_RESET;
			offset_q  <= '0;
			running_q <= 1'b1;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					REG_WAVE_SHAPE:     shape_q <= cfg_wr.data[1:0];
					REG_CONTROL_TARGET: target_q <= cfg_wr.data[1:0];
					REG_FREQ_INCREMENT: freq_q <= cfg_wr.data;
					REG_AMP_TARGET: begin
						amp_tgt_q <= cfg_wr.data;
						if (!running_q) begin
							amp_q <= cfg_wr.data;
						end
					end
					REG_RAMP_STEP:      step_q <= cfg_wr.data;
					default: ;
				endcase
			end
			if (accept) begin
				case (item.kind)
					KIND_ENABLE: begin
						phase_q   <= '0;
						offset_q  <= item.position_now;
						running_q <= 1'b1;
					end
					KIND_DISABLE: running_q <= 1'b0;
					KIND_TICK: begin
						if (running_q) begin
							phase_q <= phase_nx;
							amp_q   <= amp_nx;
						end
					end
					default: ;
				endcase
			end
		end
	end

	`SRWG_ASSERT_NEXT(a_disable_stops, accept && item.kind == KIND_DISABLE, !running_q, "disable did not stop the generator")
	`SRWG_ASSERT_NEXT(a_enable_clears, accept && item.kind == KIND_ENABLE, running_q && phase_q == '0, "enable did not clear phase")

endmodule

// ===== hdl/srwg_queue.sv =====
module srwg_queue
	import srwg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	`include "servo_reference_wave_generator_defines.svh"

	job_t              mem_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W-1:0] wr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	`SRWG_ASSERT_NOW(a_no_overflow, !(push && count_q == QCNT_W'(QUEUE_DEPTH)), "push into full queue")
	`SRWG_ASSERT_NOW(a_no_underflow, !(pop && count_q == '0), "pop from empty queue")
	`SRWG_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1), "queue count did not advance")

endmodule

// ===== hdl/srwg_back.sv =====
module srwg_back
	import srwg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  q_status_t qstat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int IW = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PRODW = FRAC_MAX + IW;
	localparam logic [IW:0] D1 = (IW+1)'(SINE_TABLE_DEPTH);
	localparam logic [IW:0] D2 = (IW+1)'(2 * SINE_TABLE_DEPTH);
	localparam logic [IW:0] D3 = (IW+1)'(3 * SINE_TABLE_DEPTH);
	localparam logic [IW:0] D4 = (IW+1)'(4 * SINE_TABLE_DEPTH);
	localparam logic [30:0] SINE_ONE = 31'h4000_0000;

	typedef logic [30:0] rom_t [0:SINE_TABLE_DEPTH];

	// Quarter-wave sine, Q1.30, from a truncated Taylor series.
	function automatic rom_t build_rom();
		rom_t        tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x  = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			for (int k = 0; k < 6; k++) begin
				t = Q30_ONE - ((x2 * t) >> 30) / SERIES_DIV[k];
			end
			s = (x * t) >> 30;
			if (s > Q30_ONE) begin
				s = Q30_ONE;
			end
			tab[i] = 31'(s);
		end
		return tab;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic adv;
	logic v1_s1, v2_s2, v3_s3, out_valid_q;

	job_t          job_s1;
	logic [IW-1:0] idx_s1;

	logic [30:0]        sine_s2;
	logic               neg_s2;
	logic [30:0]        amp_s2;
	logic signed [31:0] off_s2;
	logic               addoff_s2;
	logic [1:0]         dest_s2;

	logic [31:0]        mag_s3;
	logic               neg_s3;
	logic signed [31:0] off_s3;
	logic               addoff_s3;
	logic [1:0]         dest_s3;

	out_item_t out_item_q;

	logic [PRODW-1:0] idx_prod;
	logic [IW:0]      idx_w;
	logic [IW:0]      fold;
	logic [AW-1:0]    addr;
	logic [61:0]      amp_prod;
	logic signed [33:0] val;
	logic signed [33:0] sum;

	// Advance the whole pipe unless the output beat is stalled.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !qstat.empty;

	assign idx_prod = PRODW'(head.frac) * PRODW'(4 * SINE_TABLE_DEPTH);

	always_comb begin
		idx_w = {1'b0, idx_s1};
		if (idx_w < D1) begin
			fold = idx_w;
		end else if (idx_w < D2) begin
			fold = D2 - idx_w;
		end else if (idx_w < D3) begin
			fold = idx_w - D2;
		end else begin
			fold = D4 - idx_w;
		end
		addr = fold[AW-1:0];
	end

	assign amp_prod = {31'b0, amp_s2} * {31'b0, sine_s2};

	always_comb begin
		val = neg_s3 ? -$signed({2'b00, mag_s3}) : $signed({2'b00, mag_s3});
		sum = val + (addoff_s3 ? 34'(off_s3) : 34'sd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1 <= head;
			idx_s1 <= idx_prod[PRODW-1:FRAC_MAX];

			sine_s2   <= job_s1.square ? SINE_ONE : SINE_ROM[addr];
			neg_s2    <= job_s1.square ? !job_s1.square_hi : ({1'b0, idx_s1} >= D2);
			amp_s2    <= job_s1.amp;
			off_s2    <= job_s1.offset;
			addoff_s2 <= job_s1.add_offset;
			dest_s2   <= job_s1.dest;

			mag_s3    <= amp_prod[61:30];
			neg_s3    <= neg_s2;
			off_s3    <= off_s2;
			addoff_s3 <= addoff_s2;
			dest_s3   <= dest_s2;

			if (sum > 34'sd2147483647) begin
				out_item_q.reference <= 32'sh7fff_ffff;
			end else if (sum < -34'sd2147483648) begin
				out_item_q.reference <= 32'sh8000_0000;
			end else begin
				out_item_q.reference <= sum[31:0];
			end
			out_item_q.destination <= dest_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v1_s1       <= !qstat.empty;
			v2_s2       <= v1_s1;
			v3_s3       <= v2_s2;
			out_valid_q <= v3_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
